// ===== sv/tlc_pkg.sv =====
// Shared constants, register codes, result codes and controller states of the two-level cache lookup.
package tlc_pkg;

	localparam int TLC_L1_MAX_SETS = 1024;
	localparam int TLC_L1_MAX_WAYS = 8;
	localparam int TLC_L2_MAX_SETS = 4096;
	localparam int TLC_L2_MAX_WAYS = 16;
	localparam int TLC_ADDR_WIDTH  = 32;

	localparam int TLC_L1_AGE_W   = 4;
	localparam int TLC_L2_AGE_W   = 5;
	localparam int TLC_RAW_W      = 15;
	localparam int TLC_CFG_IDX_W  = 3;
	localparam int TLC_CFG_DATA_W = 5;
	localparam int TLC_WAY_OUT_W  = 3;

	localparam logic [3:0] TLC_RST_L1_OFFSET = 4'd5;
	localparam logic [3:0] TLC_RST_L1_INDEX  = 4'd6;
	localparam logic [3:0] TLC_RST_L1_WAYS   = 4'd4;
	localparam logic       TLC_RST_L2_PRES   = 1'b1;
	localparam logic [3:0] TLC_RST_L2_OFFSET = 4'd5;
	localparam logic [3:0] TLC_RST_L2_INDEX  = 4'd8;
	localparam logic [4:0] TLC_RST_L2_WAYS   = 5'd8;

	typedef enum logic [TLC_CFG_IDX_W-1:0] {
		REG_L1_OFFSET = 3'd0,
		REG_L1_INDEX  = 3'd1,
		REG_L1_WAYS   = 3'd2,
		REG_L2_PRES   = 3'd3,
		REG_L2_OFFSET = 3'd4,
		REG_L2_INDEX  = 3'd5,
		REG_L2_WAYS   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_L1_HIT = 2'd0,
		OUT_L2_HIT = 2'd1,
		OUT_MISS   = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_UPDATE
	} state_t;

endpackage

// ===== sv/two_level_lru_cache_lookup.sv =====
// Top level of the two-level set-associative cache lookup with age-counter replacement.
//
//   Channel    Signals                          Direction  Meaning
//   request    in_valid, in_ready, address      in         byte address to look up
//   result     out_valid, out_ready, outcome,   out        level that answered, L1 way
//              l1_way
//   config     cfg_wen, cfg_idx, cfg_wdata      in         geometry register write
//
// A request passes through accept, set read, and compare and write back; when either maximum
// set count is not a power of two, a set-reduction step comes between accept and set read.
// After reset a clearing pass writes every set of both tag memories, one set per cycle,
// until every set of the larger memory has been written; no request is taken meanwhile.
// A stalled result holds the compare stage; the next request is taken while a result waits.
module two_level_lru_cache_lookup import tlc_pkg::*; #(
	parameter int L1_MAX_SETS = TLC_L1_MAX_SETS,
	parameter int L1_MAX_WAYS = TLC_L1_MAX_WAYS,
	parameter int L2_MAX_SETS = TLC_L2_MAX_SETS,
	parameter int L2_MAX_WAYS = TLC_L2_MAX_WAYS,
	parameter int ADDR_WIDTH  = TLC_ADDR_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ADDR_WIDTH-1:0]     address,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                outcome,
	output logic [TLC_WAY_OUT_W-1:0]  l1_way,
	input  logic                      cfg_wen,
	input  logic [TLC_CFG_IDX_W-1:0]  cfg_idx,
	input  logic [TLC_CFG_DATA_W-1:0] cfg_wdata
);

	localparam int L1_SET_W  = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
	localparam int L2_SET_W  = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
	localparam int L1_WAY_W  = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
	localparam int L2_WAY_W  = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
	localparam int L1_CNT_W  = $clog2(L1_MAX_WAYS + 1);
	localparam int L2_CNT_W  = $clog2(L2_MAX_WAYS + 1);
	localparam int L1_ROW_W  = L1_MAX_WAYS * (1 + TLC_L1_AGE_W + ADDR_WIDTH);
	localparam int L2_ROW_W  = L2_MAX_WAYS * (1 + TLC_L2_AGE_W + ADDR_WIDTH);
	localparam int CLR_DEPTH = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
	localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
	localparam bit L1_POW2   = (L1_MAX_SETS & (L1_MAX_SETS - 1)) == 0;
	localparam bit L2_POW2   = (L2_MAX_SETS & (L2_MAX_SETS - 1)) == 0;
	localparam bit MOD_NEED  = !(L1_POW2 && L2_POW2);

	// The quotient by a constant set count comes from a multiplication by its rounded-up
	// reciprocal, which is exact for every index of TLC_RAW_W bits.
	localparam int L1_SH = TLC_RAW_W + $clog2(L1_MAX_SETS);
	localparam int L2_SH = TLC_RAW_W + $clog2(L2_MAX_SETS);
	localparam logic [63:0] L1_RECIP =
		((64'd1 << L1_SH) + 64'(L1_MAX_SETS) - 64'd1) / 64'(L1_MAX_SETS);
	localparam logic [63:0] L2_RECIP =
		((64'd1 << L2_SH) + 64'(L2_MAX_SETS) - 64'd1) / 64'(L2_MAX_SETS);

	state_t state_q, state_nx;

	logic [3:0] l1_off_q, l1_ib_q, l1_ways_q, l2_off_q, l2_ib_q;
	logic       l2_pres_q;
	logic [4:0] l2_ways_q;

	logic [CLR_W-1:0]         clr_cnt_q;
	logic [TLC_RAW_W-1:0]     r1_q, r2_q, r1_nx, r2_nx, raw1, raw2, ibm1, ibm2;
	logic [ADDR_WIDTH-1:0]    tag1_q, tag2_q;
	logic [63:0]              q1, q2;
	logic [L1_SET_W-1:0]      set1;
	logic [L2_SET_W-1:0]      set2;
	logic [L1_CNT_W-1:0]      l1_ways_eff;
	logic [L2_CNT_W-1:0]      l2_ways_eff;

	logic                     accept, go, do_clear, do_read;
	logic                     l1_en, l1_we, l2_en, l2_we;
	logic [L1_SET_W-1:0]      l1_addr;
	logic [L2_SET_W-1:0]      l2_addr;
	logic [L1_ROW_W-1:0]      l1_rd, l1_wr, l1_wdata;
	logic [L2_ROW_W-1:0]      l2_rd, l2_wr, l2_wdata;
	logic                     l1_hit, l2_hit;
	logic [L1_WAY_W-1:0]      l1_hw;
	logic [L2_WAY_W-1:0]      l2_hw;

	logic                     out_valid_q;
	outcome_t                 outcome_q;
	logic [TLC_WAY_OUT_W-1:0] l1_way_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_off_q  <= TLC_RST_L1_OFFSET;
			l1_ib_q   <= TLC_RST_L1_INDEX;
			l1_ways_q <= TLC_RST_L1_WAYS;
			l2_pres_q <= TLC_RST_L2_PRES;
			l2_off_q  <= TLC_RST_L2_OFFSET;
			l2_ib_q   <= TLC_RST_L2_INDEX;
			l2_ways_q <= TLC_RST_L2_WAYS;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_L1_OFFSET: l1_off_q  <= cfg_wdata[3:0];
				REG_L1_INDEX:  l1_ib_q   <= cfg_wdata[3:0];
				REG_L1_WAYS:   l1_ways_q <= cfg_wdata[3:0];
				REG_L2_PRES:   l2_pres_q <= cfg_wdata[0];
				REG_L2_OFFSET: l2_off_q  <= cfg_wdata[3:0];
				REG_L2_INDEX:  l2_ib_q   <= cfg_wdata[3:0];
				REG_L2_WAYS:   l2_ways_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign l1_ways_eff = (l1_ways_q == '0) ? L1_CNT_W'(1) :
		(int'(l1_ways_q) > L1_MAX_WAYS) ? L1_CNT_W'(L1_MAX_WAYS) : L1_CNT_W'(l1_ways_q);
	assign l2_ways_eff = (l2_ways_q == '0) ? L2_CNT_W'(1) :
		(int'(l2_ways_q) > L2_MAX_WAYS) ? L2_CNT_W'(L2_MAX_WAYS) : L2_CNT_W'(l2_ways_q);

	assign ibm1 = TLC_RAW_W'((16'd1 << l1_ib_q) - 16'd1);
	assign ibm2 = TLC_RAW_W'((16'd1 << l2_ib_q) - 16'd1);
	assign raw1 = TLC_RAW_W'(address >> l1_off_q) & ibm1;
	assign raw2 = TLC_RAW_W'(address >> l2_off_q) & ibm2;

	assign q1    = (64'(r1_q) * L1_RECIP) >> L1_SH;
	assign q2    = (64'(r2_q) * L2_RECIP) >> L2_SH;
	assign r1_nx = TLC_RAW_W'(64'(r1_q) - q1 * 64'(L1_MAX_SETS));
	assign r2_nx = TLC_RAW_W'(64'(r2_q) - q2 * 64'(L2_MAX_SETS));

	assign set1 = MOD_NEED ? L1_SET_W'(r1_q) : L1_SET_W'(r1_q & TLC_RAW_W'(L1_MAX_SETS - 1));
	assign set2 = MOD_NEED ? L2_SET_W'(r2_q) : L2_SET_W'(r2_q & TLC_RAW_W'(L2_MAX_SETS - 1));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = MOD_NEED ? ST_MOD : ST_READ;
				end
			end
			ST_MOD:    state_nx = ST_READ;
			ST_READ:   state_nx = ST_UPDATE;
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default:   state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		do_clear = (state_q == ST_CLEAR);
		do_read  = (state_q == ST_READ);
		go       = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
		accept   = in_ready && in_valid;
		l1_we    = go || (do_clear && clr_cnt_q < CLR_W'(L1_MAX_SETS));
		l2_we    = (go && !l1_hit && l2_pres_q) ||
			(do_clear && clr_cnt_q < CLR_W'(L2_MAX_SETS));
		l1_en    = l1_we || do_read;
		l2_en    = l2_we || do_read;
		l1_addr  = do_clear ? clr_cnt_q[L1_SET_W-1:0] : set1;
		l2_addr  = do_clear ? clr_cnt_q[L2_SET_W-1:0] : set2;
		l1_wdata = do_clear ? '0 : l1_wr;
		l2_wdata = do_clear ? '0 : l2_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (do_clear) begin
				clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r1_q   <= raw1;
			r2_q   <= raw2;
			tag1_q <= address >> (5'(l1_off_q) + 5'(l1_ib_q));
			tag2_q <= address >> (5'(l2_off_q) + 5'(l2_ib_q));
		end else if (state_q == ST_MOD) begin
			r1_q <= r1_nx;
			r2_q <= r2_nx;
		end
	end

	tlc_ram #(.WIDTH(L1_ROW_W), .DEPTH(L1_MAX_SETS)) u_l1_ram (
		.clk  (clk),
		.en   (l1_en),
		.we   (l1_we),
		.addr (l1_addr),
		.wdata(l1_wdata),
		.rdata(l1_rd)
	);

	tlc_ram #(.WIDTH(L2_ROW_W), .DEPTH(L2_MAX_SETS)) u_l2_ram (
		.clk  (clk),
		.en   (l2_en),
		.we   (l2_we),
		.addr (l2_addr),
		.wdata(l2_wdata),
		.rdata(l2_rd)
	);

	tlc_level #(.MAX_WAYS(L1_MAX_WAYS), .TAG_W(ADDR_WIDTH), .AGE_W(TLC_L1_AGE_W)) u_l1_level (
		.row_rd(l1_rd),
		.tag   (tag1_q),
		.ways  (l1_ways_eff),
		.hit   (l1_hit),
		.way   (l1_hw),
		.row_wr(l1_wr)
	);

	tlc_level #(.MAX_WAYS(L2_MAX_WAYS), .TAG_W(ADDR_WIDTH), .AGE_W(TLC_L2_AGE_W)) u_l2_level (
		.row_rd(l2_rd),
		.tag   (tag2_q),
		.ways  (l2_ways_eff),
		.hit   (l2_hit),
		.way   (l2_hw),
		.row_wr(l2_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			l1_way_q <= TLC_WAY_OUT_W'(l1_hw);
			if (l1_hit) begin
				outcome_q <= OUT_L1_HIT;
			end else if (l2_pres_q && l2_hit) begin
				outcome_q <= OUT_L2_HIT;
			end else begin
				outcome_q <= OUT_MISS;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;
	assign l1_way    = l1_way_q;

endmodule

// ===== sv/tlc_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module tlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== sv/tlc_level.sv =====
// Tag match, victim choice and age update for one set of one cache level.
module tlc_level #(
	parameter int MAX_WAYS = 8,
	parameter int TAG_W    = 32,
	parameter int AGE_W    = 4,
	localparam int ENT_W   = 1 + AGE_W + TAG_W,
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
	localparam int CNT_W   = $clog2(MAX_WAYS + 1)
) (
	input  logic [MAX_WAYS*ENT_W-1:0] row_rd,
	input  logic [TAG_W-1:0]          tag,
	input  logic [CNT_W-1:0]          ways,
	output logic                      hit,
	output logic [WAY_W-1:0]          way,
	output logic [MAX_WAYS*ENT_W-1:0] row_wr
);

	logic [MAX_WAYS-1:0]             vld, inuse, match, inval, ismax;
	logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  tg;
	logic [WAY_W-1:0]                hit_way, inval_way, max_way, victim;
	logic [AGE_W-1:0]                hit_age;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			tg[w]    = row_rd[w*ENT_W +: TAG_W];
			age[w]   = row_rd[w*ENT_W + TAG_W +: AGE_W];
			vld[w]   = row_rd[w*ENT_W + TAG_W + AGE_W];
			inuse[w] = (w < int'(ways));
			match[w] = inuse[w] && vld[w] && (tg[w] == tag);
			inval[w] = inuse[w] && !vld[w];
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			ismax[w] = inuse[w];
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (inuse[j] && j != w) begin
					if (j < w) begin
						ismax[w] = ismax[w] && (age[w] > age[j]);
					end else begin
						ismax[w] = ismax[w] && (age[w] >= age[j]);
					end
				end
			end
		end
	end

	always_comb begin
		hit_way   = '0;
		inval_way = '0;
		max_way   = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (inval[w]) begin
				inval_way = WAY_W'(w);
			end
			if (ismax[w]) begin
				max_way = WAY_W'(w);
			end
		end
		hit     = |match;
		victim  = (|inval) ? inval_way : max_way;
		way     = hit ? hit_way : victim;
		hit_age = age[hit_way];
	end

	always_comb begin
		row_wr = row_rd;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (inuse[w]) begin
				if (hit) begin
					if (WAY_W'(w) == hit_way) begin
						row_wr[w*ENT_W + TAG_W +: AGE_W] = '0;
					end else if (age[w] < hit_age) begin
						row_wr[w*ENT_W + TAG_W +: AGE_W] = age[w] + AGE_W'(1);
					end
				end else if (WAY_W'(w) == victim) begin
					row_wr[w*ENT_W +: ENT_W] = {1'b1, {AGE_W{1'b0}}, tag};
				end else if (age[w] != {AGE_W{1'b1}}) begin
					row_wr[w*ENT_W + TAG_W +: AGE_W] = age[w] + AGE_W'(1);
				end
			end
		end
	end

endmodule

// ===== sv/tlc_check.sv =====
// Port-level checker for the two-level cache lookup, bound to the top level.
module tlc_check import tlc_pkg::*; #(
	parameter int ADDR_WIDTH = TLC_ADDR_WIDTH
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [ADDR_WIDTH-1:0]     address,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                outcome,
	input logic [TLC_WAY_OUT_W-1:0]  l1_way,
	input logic                      cfg_wen,
	input logic [TLC_CFG_IDX_W-1:0]  cfg_idx,
	input logic [TLC_CFG_DATA_W-1:0] cfg_wdata
);

	logic l2_pres_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l2_pres_q <= TLC_RST_L2_PRES;
		end else if (cfg_wen && cfg_idx == REG_L2_PRES) begin
			l2_pres_q <= cfg_wdata[0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result dropped before it was taken.");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OUT_L1_HIT || outcome == OUT_L2_HIT || outcome == OUT_MISS))
		else $error("Outcome carries an undefined code.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A second request was taken while one is in flight.");

	a_no_l2_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_L2_HIT |-> l2_pres_q)
		else $error("Second-level hit reported with the second level absent.");

endmodule

bind two_level_lru_cache_lookup tlc_check #(.ADDR_WIDTH(ADDR_WIDTH)) u_tlc_check (.*);
